// ===== rtl/core/m7s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m7s_pkg
// Shared types and constants for the median-of-seven sorter.
// ----------------------------------------------------------------------------
package m7s_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WINDOW_LEN   = 7;
    localparam int MEDIAN_POS   = 3;
    // odd-even transposition needs as many passes as elements
    localparam int NUM_PASSES   = WINDOW_LEN;
    // compare-swap lanes working side by side in one pass
    localparam int NUM_LANES    = WINDOW_LEN / 2;

    typedef logic [SAMPLE_WIDTH-1:0] t_sample;
    typedef t_sample [WINDOW_LEN-1:0] t_window;

endpackage

// ===== rtl/core/m7s_cas.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m7s_cas
// Compare-swap lane: orders two samples into low and high.
// ----------------------------------------------------------------------------
module m7s_cas (
    input  m7s_pkg::t_sample i_a,
    input  m7s_pkg::t_sample i_b,
    output m7s_pkg::t_sample o_lo,
    output m7s_pkg::t_sample o_hi
);
    import m7s_pkg::*;

    logic swap;

    // swap when the first sample is the larger one
    assign swap = (i_a > i_b);
    assign o_lo = swap ? i_b : i_a;
    assign o_hi = swap ? i_a : i_b;

endmodule

// ===== rtl/core/m7s_pass.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m7s_pass
// One transposition pass: compare-swap lanes on adjacent pairs, merged back
// into a registered window, with an elastic valid/ready stage.
// ----------------------------------------------------------------------------
module m7s_pass (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_odd,
    input  logic                i_valid,
    output logic                o_ready,
    input  m7s_pkg::t_window    i_window,
    output logic                o_valid,
    input  logic                i_ready,
    output m7s_pkg::t_window    o_window
);
    import m7s_pkg::*;

    logic    r_valid;
    t_window r_window;
    t_window n_window;
    t_sample lane_a  [NUM_LANES];
    t_sample lane_b  [NUM_LANES];
    t_sample lane_lo [NUM_LANES];
    t_sample lane_hi [NUM_LANES];
    logic    load;

    // pick the pair for each lane: even passes start at 0, odd passes at 1
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        always_comb begin
            if (i_odd) begin
                lane_a[j] = i_window[2*j+1];
                lane_b[j] = i_window[2*j+2];
            end else begin
                lane_a[j] = i_window[2*j];
                lane_b[j] = i_window[2*j+1];
            end
        end

        m7s_cas u_cas (
            .i_a  (lane_a[j]),
            .i_b  (lane_b[j]),
            .o_lo (lane_lo[j]),
            .o_hi (lane_hi[j])
        );
    end

    // merge lane results back into the window; unpaired element passes through
    always_comb begin
        n_window = i_window;
        for (int j = 0; j < NUM_LANES; j++) begin
            if (i_odd) begin
                n_window[2*j+1] = lane_lo[j];
                n_window[2*j+2] = lane_hi[j];
            end else begin
                n_window[2*j]   = lane_lo[j];
                n_window[2*j+1] = lane_hi[j];
            end
        end
    end

    // take a new transaction when empty or when the held one moves on
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_window <= n_window;
        end
    end

    assign o_valid  = r_valid;
    assign o_window = r_window;

endmodule

// ===== rtl/core/median_of_seven_sorter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_seven_sorter_top
// Sorts a window of seven unsigned samples and reports the median.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries seven samples per transaction.
//   Output channel (o_valid / i_ready) returns the seven samples in ascending
//   order plus the median (fourth smallest), one result per input.
//   The sort is an odd-even transposition network of seven passes; each pass
//   is one register stage with three compare-swap lanes, and a result is
//   presented from the register of the seventh pass. One transaction is
//   accepted every cycle as long as the output side keeps taking results;
//   the 16-bit compares, side by side in each stage, set the clock period.
//   Every stage holds its own transaction, so the pipeline keeps filling
//   while a result waits; when all seven stages are full and i_ready is low,
//   o_ready drops and every stage holds its contents unchanged.
//   Reset clears all stage valid flags; no output is presented until new
//   input arrives. There is no configuration and no state between windows.
// ----------------------------------------------------------------------------
module median_of_seven_sorter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  m7s_pkg::t_sample    i_sample_0,
    input  m7s_pkg::t_sample    i_sample_1,
    input  m7s_pkg::t_sample    i_sample_2,
    input  m7s_pkg::t_sample    i_sample_3,
    input  m7s_pkg::t_sample    i_sample_4,
    input  m7s_pkg::t_sample    i_sample_5,
    input  m7s_pkg::t_sample    i_sample_6,
    output logic                o_valid,
    input  logic                i_ready,
    output m7s_pkg::t_sample    o_median,
    output m7s_pkg::t_sample    o_sorted_0,
    output m7s_pkg::t_sample    o_sorted_1,
    output m7s_pkg::t_sample    o_sorted_2,
    output m7s_pkg::t_sample    o_sorted_3,
    output m7s_pkg::t_sample    o_sorted_4,
    output m7s_pkg::t_sample    o_sorted_5,
    output m7s_pkg::t_sample    o_sorted_6
);
    import m7s_pkg::*;

    t_window stage_window [NUM_PASSES+1];
    logic    stage_valid  [NUM_PASSES+1];
    logic    stage_ready  [NUM_PASSES+1];

    // gather the input window
    assign stage_window[0] = {i_sample_6, i_sample_5, i_sample_4, i_sample_3,
                              i_sample_2, i_sample_1, i_sample_0};
    assign stage_valid[0]  = i_valid;
    assign o_ready         = stage_ready[0];

    // chain of transposition passes, alternating even and odd pairing
    for (genvar p = 0; p < NUM_PASSES; p++) begin : g_pass
        m7s_pass u_pass (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_odd    ((p % 2) == 1),
            .i_valid  (stage_valid[p]),
            .o_ready  (stage_ready[p]),
            .i_window (stage_window[p]),
            .o_valid  (stage_valid[p+1]),
            .i_ready  (stage_ready[p+1]),
            .o_window (stage_window[p+1])
        );
    end

    // drive the result from the last stage
    assign stage_ready[NUM_PASSES] = i_ready;
    assign o_valid    = stage_valid[NUM_PASSES];
    assign o_median   = stage_window[NUM_PASSES][MEDIAN_POS];
    assign o_sorted_0 = stage_window[NUM_PASSES][0];
    assign o_sorted_1 = stage_window[NUM_PASSES][1];
    assign o_sorted_2 = stage_window[NUM_PASSES][2];
    assign o_sorted_3 = stage_window[NUM_PASSES][3];
    assign o_sorted_4 = stage_window[NUM_PASSES][4];
    assign o_sorted_5 = stage_window[NUM_PASSES][5];
    assign o_sorted_6 = stage_window[NUM_PASSES][6];

    // presented result is in ascending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sorted_0 <= o_sorted_1) && (o_sorted_1 <= o_sorted_2) &&
                    (o_sorted_2 <= o_sorted_3) && (o_sorted_3 <= o_sorted_4) &&
                    (o_sorted_4 <= o_sorted_5) && (o_sorted_5 <= o_sorted_6))
        else $error("result window not in ascending order");

    // an accepted transaction always lands in the first stage
    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> stage_valid[1])
        else $error("accepted transaction lost at first stage");

    // input side stalls only when the whole pipeline is full and blocked; checked on the first, fourth and last stages
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && stage_valid[1] && stage_valid[4]))
        else $error("input stalled while pipeline has room");

    // a presented result that is not taken keeps its median
    a_hold_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_median)))
        else $error("stalled result changed");

endmodule
